/* rtl/trwd_pkg.sv */
// Shared types, register codes and constants for the throttle ramp and waveform drive.
`timescale 1ns / 1ps
`default_nettype none

package trwd_pkg;

  localparam int SPEED_MAX      = 1023;
  localparam int WAVE_STEPS_DEF = 100;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRI_THRESH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC  = 3'd4;

  // Brake levels
  localparam logic [2:0] BRAKE_OFF       = 3'd0;
  localparam logic [2:0] BRAKE_LIGHT     = 3'd1;
  localparam logic [2:0] BRAKE_MEDIUM    = 3'd2;
  localparam logic [2:0] BRAKE_HEAVY     = 3'd3;
  localparam logic [2:0] BRAKE_EMERGENCY = 3'd4;

  // Drive waveform kinds
  localparam logic [1:0] KIND_CLASSIC   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE  = 2'd1;
  localparam logic [1:0] KIND_TRAPEZOID = 2'd2;

  // Reciprocal tables for the trapezoid slopes: Q16, wide enough for any step count
  localparam int RCP_SHIFT = 16;
  localparam int RCP_W     = 23;

  // Target clamp as seen by a 10-bit speed
  localparam logic [9:0] SPEED_CAP = (SPEED_MAX > 1023) ? 10'd1023 : 10'(SPEED_MAX);

  typedef struct packed {
    logic [9:0]  interval;
    logic [7:0]  step;
    logic [9:0]  tri_thresh;
    logic [9:0]  slew;
    logic [14:0] phase_inc;
  } cfg_t;

  typedef struct packed {
    logic [9:0] target;
    logic [2:0] brake;
    logic       fwd;
    logic       wen;
  } item_t;

  typedef struct packed {
    logic [9:0] duty;
    logic [1:0] kind;
  } drive_t;

endpackage

`default_nettype wire

/* rtl/throttle_ramp_waveform_drive.sv */
// Top level: handshakes, configuration registers, input and result registers.
// Usage:
//   One input item is one 1 ms tick: target speed, brake level, direction and
//   waveform enable. Each accepted item yields exactly one result item: drive
//   duty, ramped speed, waveform kind and the two H-bridge inputs.
//   Input and result channels use valid/ready; an item moves when both are high.
//   After input acceptance the item sits in the input register while the ramp
//   and waveform logic run, then lands in the result register, where result
//   valid rises. Throughput is one item per cycle while the receiver is ready;
//   the speed and waveform state advance exactly once per item, as it leaves
//   the input register.
//   When the receiver stalls, the result register holds and the input register
//   still takes one more item; input ready drops only when both are full.
//   Configuration writes use their own valid/ready channel with an index and
//   data; ready is always high. Write only while no item is in flight.
//   Synchronous reset loads the register defaults, zeroes speed and waveform
//   state with the triangle set to rise, and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module throttle_ramp_waveform_drive #(
  parameter int WAVE_STEPS = trwd_pkg::WAVE_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [9:0]                         goal_speed,
  input  logic [2:0]                         brake_sel,
  input  logic                               forward,
  input  logic                               waveform_enable,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [9:0]                         pwm_duty,
  output logic [9:0]                         speed_now,
  output logic [1:0]                         wave_kind,
  output logic                               bridge_in1,
  output logic                               bridge_in2,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [trwd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trwd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import trwd_pkg::*;

  cfg_t   cfg;
  logic   s1_valid;
  item_t  s1_item;
  logic   s1_go;
  logic   out_free;
  logic [9:0] speed_next;
  drive_t drive;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign s1_go     = s1_valid && out_free;
  assign in_ready  = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval   <= 10'd20;
      cfg.step       <= 8'd1;
      cfg.tri_thresh <= 10'd300;
      cfg.slew       <= 10'd50;
      cfg.phase_inc  <= 15'd3200;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INTERVAL:   cfg.interval   <= cfg_data[9:0];
        CFG_STEP:       cfg.step       <= cfg_data[7:0];
        CFG_TRI_THRESH: cfg.tri_thresh <= cfg_data[9:0];
        CFG_SLEW:       cfg.slew       <= cfg_data[9:0];
        CFG_PHASE_INC:  cfg.phase_inc  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.target <= goal_speed;
      s1_item.brake  <= brake_sel;
      s1_item.fwd    <= forward;
      s1_item.wen    <= waveform_enable;
    end
  end

  trwd_ramp u_ramp (
    .clk        (clk),
    .rst        (rst),
    .adv        (s1_go),
    .item       (s1_item),
    .cfg        (cfg),
    .speed_next (speed_next)
  );

  trwd_wave #(
    .WAVE_STEPS (WAVE_STEPS)
  ) u_wave (
    .clk   (clk),
    .rst   (rst),
    .adv   (s1_go),
    .wen   (s1_item.wen),
    .speed (speed_next),
    .cfg   (cfg),
    .drive (drive)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      pwm_duty   <= drive.duty;
      speed_now  <= speed_next;
      wave_kind  <= drive.kind;
      bridge_in1 <= s1_item.fwd;
      bridge_in2 <= !s1_item.fwd;
    end
  end

  // a stalled item in the input register must not be dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> s1_valid)
    else $error("input register item lost during stall");

  a_classic_duty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wave_kind == KIND_CLASSIC) |-> (pwm_duty == speed_now))
    else $error("classic duty differs from speed");

  a_trap_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wave_kind == KIND_TRAPEZOID) |-> (pwm_duty <= speed_now))
    else $error("trapezoid duty above speed");

endmodule

`default_nettype wire

/* rtl/trwd_ramp.sv */
// Momentum counter and speed ramp with brake handling.
`timescale 1ns / 1ps
`default_nettype none

module trwd_ramp (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  trwd_pkg::item_t  item,
  input  trwd_pkg::cfg_t   cfg,
  output logic [9:0]       speed_next
);
  import trwd_pkg::*;

  logic [9:0]  speed;
  logic [9:0]  interval_count;
  logic [9:0]  interval_count_next;
  logic [9:0]  target;
  logic [10:0] cnt_inc;
  logic        fire;
  logic [7:0]  brake_dec;
  logic [10:0] up_sum;
  logic [9:0]  ramped;

  always_comb begin
    target  = (item.target > SPEED_CAP) ? SPEED_CAP : item.target;
    cnt_inc = {1'b0, interval_count} + 11'd1;
    fire    = (cnt_inc >= {1'b0, cfg.interval});
    up_sum  = {1'b0, speed} + {3'b000, cfg.step};

    unique case (item.brake)
      BRAKE_LIGHT:     brake_dec = 8'd2;
      BRAKE_MEDIUM:    brake_dec = 8'd4;
      BRAKE_HEAVY:     brake_dec = 8'd8;
      BRAKE_EMERGENCY: brake_dec = 8'd20;
      default:         brake_dec = cfg.step;
    endcase

    priority if (item.brake != BRAKE_OFF) begin
      ramped = (speed > {2'b00, brake_dec}) ? speed - {2'b00, brake_dec} : 10'd0;
    end else if (speed < target) begin
      ramped = (up_sum > {1'b0, target}) ? target : up_sum[9:0];
    end else if (speed > target) begin
      // stop at the target when the last step would overshoot it
      ramped = ((speed - target) < {2'b00, cfg.step}) ? target
                                                      : speed - {2'b00, cfg.step};
    end else begin
      ramped = speed;
    end

    speed_next          = fire ? ramped : speed;
    interval_count_next = fire ? 10'd0 : cnt_inc[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed          <= 10'd0;
      interval_count <= 10'd0;
    end else if (adv) begin
      speed          <= speed_next;
      interval_count <= interval_count_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/trwd_wave.sv */
// Drive waveform generator: classic, triangle slew and phase-stepped trapezoid.
`timescale 1ns / 1ps
`default_nettype none

module trwd_wave #(
  parameter int WAVE_STEPS = trwd_pkg::WAVE_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             wen,
  input  logic [9:0]       speed,
  input  trwd_pkg::cfg_t   cfg,
  output trwd_pkg::drive_t drive
);
  import trwd_pkg::*;

  localparam int STEP_W  = $clog2(WAVE_STEPS);
  localparam int RISE    = WAVE_STEPS * 2 / 10;
  localparam int FLAT    = WAVE_STEPS * 6 / 10;
  localparam int PROD_W  = 10 + RCP_W;
  localparam int QUOT_W  = PROD_W - RCP_SHIFT;
  localparam int RCP_N   = 2 ** STEP_W;

  typedef logic [STEP_W-1:0] mod_lut_t [256];
  typedef logic [RCP_W-1:0]  rcp_lut_t [RCP_N];

  function automatic mod_lut_t build_mod_lut();
    mod_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = STEP_W'(i % WAVE_STEPS);
    end
    return lut;
  endfunction

  // ceil(k * 2^16 / RISE): exact floor division for 10-bit speeds; fall shares RISE
  function automatic rcp_lut_t build_rcp_lut();
    rcp_lut_t lut;
    for (int k = 0; k < RCP_N; k++) begin
      lut[k] = RCP_W'(((k << RCP_SHIFT) + RISE - 1) / RISE);
    end
    return lut;
  endfunction

  localparam mod_lut_t MOD_LUT = build_mod_lut();
  localparam rcp_lut_t RCP_LUT = build_rcp_lut();

  logic [9:0]        tri_level;
  logic              tri_up;
  logic [STEP_W-1:0] wave_step;
  logic [7:0]        phase_frac;
  logic              enable_prev;

  logic [9:0]        tri_level_next;
  logic              tri_up_next;
  logic [STEP_W-1:0] wave_step_next;
  logic [7:0]        phase_frac_next;

  logic              en_rise;
  logic [9:0]        tri_cur;
  logic              up_cur;
  logic [STEP_W-1:0] step_cur;
  logic [11:0]       tri_sum;
  logic [9:0]        tri_new;
  logic              up_new;
  logic [15:0]       phase_sum;
  logic [7:0]        step_idx;
  logic [STEP_W-1:0] step_new;
  logic              in_rise;
  logic              in_flat;
  logic [STEP_W-1:0] mul_idx;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [9:0]        trap_duty;

  always_comb begin
    // turning the generator on restarts both waveforms
    en_rise  = wen && !enable_prev;
    tri_cur  = en_rise ? 10'd0 : tri_level;
    up_cur   = en_rise ? 1'b1 : tri_up;
    step_cur = en_rise ? '0 : wave_step;

    tri_sum = {2'b00, tri_cur} + {2'b00, cfg.slew};
    if (up_cur) begin
      if (tri_sum >= {2'b00, speed}) begin
        tri_new = speed;
        up_new  = 1'b0;
      end else begin
        tri_new = tri_sum[9:0];
        up_new  = 1'b1;
      end
    end else begin
      if (tri_cur <= cfg.slew) begin
        tri_new = 10'd0;
        up_new  = 1'b1;
      end else begin
        tri_new = tri_cur - cfg.slew;
        up_new  = 1'b0;
      end
    end

    phase_sum = {8'h00, phase_frac} + {1'b0, cfg.phase_inc};
    step_idx  = 8'(step_cur) + phase_sum[15:8];
    step_new  = MOD_LUT[step_idx];
    in_rise   = (step_new < STEP_W'(RISE));
    in_flat   = (step_new < STEP_W'(RISE + FLAT));
    mul_idx   = in_rise ? step_new : step_new - STEP_W'(RISE + FLAT);
    prod      = PROD_W'(speed) * PROD_W'(RCP_LUT[mul_idx]);
    quot      = prod[PROD_W-1:RCP_SHIFT];

    priority if (in_rise) begin
      trap_duty = quot[9:0];
    end else if (in_flat) begin
      trap_duty = speed;
    end else begin
      // saturate where the fall runs longer than its nominal length
      trap_duty = (quot >= QUOT_W'(speed)) ? 10'd0 : speed - quot[9:0];
    end

    tri_level_next  = tri_cur;
    tri_up_next     = up_cur;
    wave_step_next  = step_cur;
    phase_frac_next = phase_frac;

    priority if (!wen) begin
      drive.duty = speed;
      drive.kind = KIND_CLASSIC;
    end else if (speed == 10'd0) begin
      drive.duty = 10'd0;
      drive.kind = (cfg.tri_thresh != 10'd0) ? KIND_TRIANGLE : KIND_TRAPEZOID;
    end else if (speed < cfg.tri_thresh) begin
      drive.duty     = tri_new;
      drive.kind     = KIND_TRIANGLE;
      tri_level_next = tri_new;
      tri_up_next    = up_new;
    end else begin
      drive.duty      = trap_duty;
      drive.kind      = KIND_TRAPEZOID;
      wave_step_next  = step_new;
      phase_frac_next = phase_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tri_level   <= 10'd0;
      tri_up      <= 1'b1;
      wave_step   <= '0;
      phase_frac  <= 8'h00;
      enable_prev <= 1'b0;
    end else if (adv) begin
      tri_level   <= tri_level_next;
      tri_up      <= tri_up_next;
      wave_step   <= wave_step_next;
      phase_frac  <= phase_frac_next;
      enable_prev <= wen;
    end
  end

endmodule

`default_nettype wire

/* tb/trwd_checker.sv */
// Checker for the throttle ramp and waveform drive: watches the channels, predicts and compares.
`timescale 1ns / 1ps

module trwd_checker #(
  parameter int WAVE_STEPS = trwd_pkg::WAVE_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [9:0]                     goal_speed,
  input  logic [2:0]                     brake_sel,
  input  logic                           forward,
  input  logic                           waveform_enable,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [9:0]                     pwm_duty,
  input  logic [9:0]                     speed_now,
  input  logic [1:0]                     wave_kind,
  input  logic                           bridge_in1,
  input  logic                           bridge_in2,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [trwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trwd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             error_count,
  output int                             pending_count
);
  import trwd_pkg::*;

  typedef struct packed {
    logic [9:0] duty;
    logic [9:0] speed;
    logic [1:0] kind;
    logic       in1;
    logic       in2;
  } drive_result_t;

  localparam int RISE_LEN = (WAVE_STEPS * 2) / 10;
  localparam int FLAT_LEN = (WAVE_STEPS * 6) / 10;
  localparam int FALL_LEN = RISE_LEN;
  localparam int MAX_PRINTS = 40;

  // Register copies
  logic [9:0]  cfg_interval;
  logic [7:0]  cfg_ramp_step;
  logic [9:0]  cfg_tri_thresh;
  logic [9:0]  cfg_slew;
  logic [14:0] cfg_phase_inc;

  // Drive state copies
  logic [9:0]  speed_reg;
  logic [9:0]  tick_count;
  logic [10:0] tri_level;
  logic        tri_rising;
  logic [6:0]  wave_pos;
  logic [7:0]  phase_frac;
  logic        wen_prev;

  drive_result_t drive_q[$];
  int            results_seen = 0;

  initial error_count = 0;
  initial pending_count = 0;

  task automatic report(input string msg);
    if (error_count < MAX_PRINTS) $display("ERROR: %s", msg);
    error_count++;
  endtask

  function automatic int brake_decrement(input logic [2:0] lvl);
    case (lvl)
      BRAKE_LIGHT:     return 2;
      BRAKE_MEDIUM:    return 4;
      BRAKE_HEAVY:     return 8;
      BRAKE_EMERGENCY: return 20;
      default:         return int'(cfg_ramp_step);
    endcase
  endfunction

  function automatic drive_result_t predict_tick(input logic [9:0] tgt_in, input logic [2:0] brake,
                                                 input logic fwd, input logic wen);
    drive_result_t r;
    int tgt;
    int spd;
    int dec;
    int nxt;
    int lvl;
    int sum_q8;
    int seg;
    int drop;
    tgt = int'(tgt_in);
    if (tgt > SPEED_MAX) tgt = SPEED_MAX;
    // restart the waveform when the generator is switched on
    if (wen && !wen_prev) begin
      tri_level = '0;
      tri_rising = 1'b1;
      wave_pos = '0;
    end
    wen_prev = wen;

    spd = int'(speed_reg);
    nxt = int'(tick_count) + 1;
    if (nxt >= int'(cfg_interval)) begin
      if (brake != BRAKE_OFF) begin
        dec = brake_decrement(brake);
        spd = (spd > dec) ? spd - dec : 0;
      end else if (spd < tgt) begin
        spd = (spd + int'(cfg_ramp_step) > tgt) ? tgt : spd + int'(cfg_ramp_step);
      end else if (spd > tgt) begin
        spd = (spd - tgt < int'(cfg_ramp_step)) ? tgt : spd - int'(cfg_ramp_step);
      end
      speed_reg = 10'(spd);
      tick_count = '0;
    end else begin
      tick_count = 10'(nxt);
    end

    r.speed = speed_reg;
    r.in1 = fwd;
    r.in2 = !fwd;
    if (!wen) begin
      r.duty = speed_reg;
      r.kind = KIND_CLASSIC;
    end else if (speed_reg == '0) begin
      r.duty = '0;
      r.kind = (cfg_tri_thresh != '0) ? KIND_TRIANGLE : KIND_TRAPEZOID;
    end else if (speed_reg < cfg_tri_thresh) begin
      lvl = int'(tri_level);
      if (tri_rising) begin
        lvl = lvl + int'(cfg_slew);
        if (lvl >= spd) begin
          lvl = spd;
          tri_rising = 1'b0;
        end
      end else begin
        lvl = lvl - int'(cfg_slew);
        if (lvl <= 0) begin
          lvl = 0;
          tri_rising = 1'b1;
        end
      end
      tri_level = 11'(lvl);
      r.duty = 10'(lvl);
      r.kind = KIND_TRIANGLE;
    end else begin
      sum_q8 = int'(phase_frac) + int'(cfg_phase_inc);
      phase_frac = 8'(sum_q8 & 255);
      wave_pos = 7'((int'(wave_pos) + (sum_q8 >> 8)) % WAVE_STEPS);
      seg = int'(wave_pos);
      if (seg < RISE_LEN) begin
        r.duty = 10'((spd * seg) / RISE_LEN);
      end else if (seg < RISE_LEN + FLAT_LEN) begin
        r.duty = speed_reg;
      end else begin
        drop = (spd * (seg - RISE_LEN - FLAT_LEN)) / FALL_LEN;
        r.duty = (drop >= spd) ? 10'd0 : 10'(spd - drop);
      end
      r.kind = KIND_TRAPEZOID;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    drive_result_t want;
    if (rst) begin
      cfg_interval   = 10'd20;
      cfg_ramp_step  = 8'd1;
      cfg_tri_thresh = 10'd300;
      cfg_slew       = 10'd50;
      cfg_phase_inc  = 15'd3200;
      speed_reg      = '0;
      tick_count     = '0;
      tri_level      = '0;
      tri_rising     = 1'b1;
      wave_pos       = '0;
      phase_frac     = '0;
      wen_prev       = 1'b0;
      drive_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INTERVAL:   cfg_interval   = cfg_data[9:0];
          CFG_STEP:       cfg_ramp_step  = cfg_data[7:0];
          CFG_TRI_THRESH: cfg_tri_thresh = cfg_data[9:0];
          CFG_SLEW:       cfg_slew       = cfg_data[9:0];
          CFG_PHASE_INC:  cfg_phase_inc  = cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        drive_q.push_back(predict_tick(goal_speed, brake_sel, forward, waveform_enable));
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = drive_q.pop_front();
          if (pwm_duty !== want.duty)
            report($sformatf("result %0d pwm_duty %0d, expected %0d",
                             results_seen, pwm_duty, want.duty));
          if (speed_now !== want.speed)
            report($sformatf("result %0d speed_now %0d, expected %0d",
                             results_seen, speed_now, want.speed));
          if (wave_kind !== want.kind)
            report($sformatf("result %0d wave_kind %0d, expected %0d",
                             results_seen, wave_kind, want.kind));
          if (bridge_in1 !== want.in1)
            report($sformatf("result %0d bridge_in1 %b, expected %b",
                             results_seen, bridge_in1, want.in1));
          if (bridge_in2 !== want.in2)
            report($sformatf("result %0d bridge_in2 %b, expected %b",
                             results_seen, bridge_in2, want.in2));
        end
        results_seen++;
      end
    end
    pending_count = drive_q.size();
  end

endmodule

/* tb/tb.sv */
// Testbench top: clock, reset, tick and register stimulus, idling, verdict.
`timescale 1ns / 1ps

module tb;
  import trwd_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SEGMENTS     = 10;
  localparam int SEG_ITEMS    = 103;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [9:0]            goal_speed = '0;
  logic [2:0]            brake_sel = '0;
  logic                  forward = 1'b0;
  logic                  waveform_enable = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [9:0]            pwm_duty;
  logic [9:0]            speed_now;
  logic [1:0]            wave_kind;
  logic                  bridge_in1;
  logic                  bridge_in2;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int error_count;
  int pending_count;
  int tx_idle_pct = 7;
  int rx_idle_pct = 66;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int cycles = 0;

  throttle_ramp_waveform_drive u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .goal_speed(goal_speed), .brake_sel(brake_sel),
    .forward(forward), .waveform_enable(waveform_enable),
    .out_valid(out_valid), .out_ready(out_ready),
    .pwm_duty(pwm_duty), .speed_now(speed_now), .wave_kind(wave_kind),
    .bridge_in1(bridge_in1), .bridge_in2(bridge_in2),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  trwd_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .goal_speed(goal_speed), .brake_sel(brake_sel),
    .forward(forward), .waveform_enable(waveform_enable),
    .out_valid(out_valid), .out_ready(out_ready),
    .pwm_duty(pwm_duty), .speed_now(speed_now), .wave_kind(wave_kind),
    .bridge_in1(bridge_in1), .bridge_in2(bridge_in2),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(error_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off so the block fills up
  always @(posedge clk) begin
    if (hold_armed && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_tick(input logic [9:0] tgt, input logic [2:0] brk,
                           input logic fwd, input logic wen);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    goal_speed <= tgt;
    brake_sel <= brk;
    forward <= fwd;
    waveform_enable <= wen;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic program_regs(input logic [14:0] ival, input logic [14:0] rstep,
                              input logic [14:0] thr, input logic [14:0] slw,
                              input logic [14:0] pinc);
    write_reg(CFG_INTERVAL, ival);
    write_reg(CFG_STEP, rstep);
    write_reg(CFG_TRI_THRESH, thr);
    write_reg(CFG_SLEW, slw);
    write_reg(CFG_PHASE_INC, pinc);
    cfg_valid <= 1'b0;
  endtask

  // Hold the input side until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  task automatic program_random();
    logic [14:0] ival, rstep, thr, slw, pinc;
    case ($urandom_range(9))
      0: ival = 15'd0;
      1: ival = 15'd1023;
      2: ival = 15'($urandom);
      default: ival = 15'($urandom_range(1, 6));
    endcase
    case ($urandom_range(7))
      0: rstep = 15'd0;
      1: rstep = 15'd255;
      2: rstep = 15'($urandom);
      default: rstep = 15'($urandom_range(1, 255));
    endcase
    case ($urandom_range(7))
      0: thr = 15'd0;
      1: thr = 15'd1023;
      2: thr = 15'($urandom);
      default: thr = 15'($urandom_range(1023));
    endcase
    case ($urandom_range(7))
      0: slw = 15'd0;
      1: slw = 15'd1;
      2: slw = 15'd1023;
      default: slw = 15'($urandom_range(1, 200));
    endcase
    case ($urandom_range(7))
      0: pinc = 15'd1;
      1: pinc = 15'd25599;
      2: pinc = 15'h7fff;
      3: pinc = 15'($urandom);
      default: pinc = 15'($urandom_range(1, 25599));
    endcase
    program_regs(ival, rstep, thr, slw, pinc);
  endtask

  initial begin
    logic [9:0] tgt;
    logic [2:0] brk;
    logic       wen;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks, first at the reset register values
    send_tick(10'd0, '0, 1'b1, 1'b0);
    send_tick(10'd1023, '0, 1'b0, 1'b1);
    drain();
    program_regs(15'd1, 15'd255, 15'd1023, 15'd1023, 15'd25599);
    // climb through triangle range, then reach full speed for the trapezoid
    repeat (5) send_tick(10'd1023, '0, 1'b1, 1'b1);
    send_tick(10'd1023, '0, 1'b0, 1'b0);
    for (int lvl = 1; lvl < 8; lvl++) send_tick(10'd1023, 3'(lvl), lvl[0], 1'b1);
    send_tick(10'd0, '0, 1'b1, 1'b1);
    drain();
    // write to an unused index: must change nothing
    write_reg(CFG_IDX_W'(CFG_PHASE_INC + 1 + $urandom_range(2)), 15'($urandom));
    program_regs(15'd0, 15'd0, 15'd0, 15'd1, 15'h7fff);
    send_tick(10'd500, '0, 1'b1, 1'b1);
    repeat (3) send_tick(10'd0, 3'd4, 1'b1, 1'b1);
    send_tick(10'd0, '0, 1'b0, 1'b0);
    send_tick(10'd0, '0, 1'b1, 1'b1);

    tgt = '0;
    wen = 1'b1;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 4) begin
        tx_idle_pct = 66;
        rx_idle_pct = 7;
      end else if (seg == 7) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      drain();
      program_random();
      if (seg == 1) hold_armed = 1'b1;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(9) == 0) begin
          // noise: anything the fields allow
          send_tick(10'($urandom), 3'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          if ($urandom_range(19) == 0) begin
            case ($urandom_range(3))
              0: tgt = 10'd0;
              1: tgt = 10'd1023;
              default: tgt = 10'($urandom_range(1023));
            endcase
          end
          if ($urandom_range(24) == 0) wen = !wen;
          brk = ($urandom_range(9) == 0) ? 3'($urandom_range(1, 7)) : '0;
          send_tick(tgt, brk, 1'($urandom), wen);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
